// ===== hw/rtl/imhw_pkg.sv =====
// ----------------------------------------------------------------------------
// imhw_pkg
// Shared types and constants of the indexed max-heap worklist.
// ----------------------------------------------------------------------------
package imhw_pkg;

  localparam int unsigned HeapCapacity = 1024;
  localparam int unsigned NodeCount    = 4096;
  localparam int unsigned PriorityBits = 32;
  localparam int unsigned NodeIdBits   = 12;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_QUERY = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOT_NEW = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  localparam logic [1:0] KIND_UNVISITED = 2'd0;
  localparam logic [1:0] KIND_VISITED   = 2'd1;
  localparam logic [1:0] KIND_QUEUED    = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MARK,
    S_CHK,
    S_UP,
    S_UP_CMP,
    S_POP_TOP,
    S_POP_LAST,
    S_DN,
    S_DN_L,
    S_DN_R,
    S_POP_MARK,
    S_FIN
  } state_e;

endpackage

// ===== hw/rtl/imhw_req_if.sv =====
// ----------------------------------------------------------------------------
// imhw_req_if
// Request channel of the heap worklist: opcode, node id and priority.
// ----------------------------------------------------------------------------
interface imhw_req_if #(
  parameter int unsigned PRIO_W = imhw_pkg::PriorityBits
);
  logic                              valid;
  logic                              ready;
  logic [1:0]                        opcode;
  logic [imhw_pkg::NodeIdBits-1:0]   node_id;
  logic signed [PRIO_W-1:0]          priority_req;

  modport source (output valid, opcode, node_id, priority_req, input ready);
  modport sink   (input valid, opcode, node_id, priority_req, output ready);
endinterface

// ===== hw/rtl/imhw_rsp_if.sv =====
// ----------------------------------------------------------------------------
// imhw_rsp_if
// Response channel of the heap worklist: status, popped node and fill level.
// ----------------------------------------------------------------------------
interface imhw_rsp_if #(
  parameter int unsigned CNT_W = $clog2(imhw_pkg::HeapCapacity + 1)
);
  logic                              valid;
  logic                              ready;
  logic [1:0]                        status;
  logic                              popped_valid;
  logic [imhw_pkg::NodeIdBits-1:0]   popped_node;
  logic [CNT_W-1:0]                  entry_count;
  logic                              is_empty;

  modport source (output valid, status, popped_valid, popped_node, entry_count,
                  is_empty, input ready);
  modport sink   (input valid, status, popped_valid, popped_node, entry_count,
                  is_empty, output ready);
endinterface

// ===== hw/rtl/indexed_max_heap_worklist.sv =====
// ----------------------------------------------------------------------------
// indexed_max_heap_worklist
// Indexed binary max-heap of node ids with a per-node mark memory.
// ----------------------------------------------------------------------------
// A push of a valid id reads the node mark, may read the heap slot it names,
// then sifts up parent by parent; a pop reads the top and last slots, then
// sifts down level by level; pop on empty, clear and query go straight to the
// response. One request at a time: the next is taken in the cycle after the
// response register is loaded. After reset a clearing pass writes every node
// mark, during which no request is accepted; configuration writes are taken.
module indexed_max_heap_worklist #(
  parameter int unsigned HEAP_CAPACITY = imhw_pkg::HeapCapacity,
  parameter int unsigned NODE_COUNT    = imhw_pkg::NodeCount,
  parameter int unsigned PRIORITY_BITS = imhw_pkg::PriorityBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        multi_enqueue_we_i,
  input  logic        multi_enqueue_i,
  imhw_req_if.sink    req_i,
  imhw_rsp_if.source  rsp_o
);
  import imhw_pkg::*;

  localparam int unsigned CW  = $clog2(HEAP_CAPACITY + 1);
  localparam int unsigned NW  = $clog2(NODE_COUNT);
  localparam int unsigned PW  = PRIORITY_BITS;
  localparam int unsigned IDW = NodeIdBits;

  // Heap memory, slots 1..HEAP_CAPACITY.
  logic [IDW-1:0] heap_node_mem [HEAP_CAPACITY+1];
  logic [PW-1:0]  heap_key_mem  [HEAP_CAPACITY+1];
  // Node mark memory: kind and heap slot.
  logic [1:0]     mark_kind_mem [NODE_COUNT];
  logic [CW-1:0]  mark_slot_mem [NODE_COUNT];

  state_e         state_q, state_d;
  logic [NW-1:0]  clr_q, clr_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [CW-1:0]  k_q, k_d;
  logic [IDW-1:0] node_q, node_d;
  logic [PW-1:0]  key_q, key_d;
  logic [IDW-1:0] top_q, top_d;
  logic [IDW-1:0] cnode_q, cnode_d;
  logic [PW-1:0]  ckey_q, ckey_d;
  status_e        st_q, st_d;
  logic           pv_q, pv_d;
  logic           multi_q;

  logic           h_we, h_re;
  logic [CW-1:0]  h_waddr, h_raddr;
  logic [IDW-1:0] h_wnode, h_rnode_q;
  logic [PW-1:0]  h_wkey, h_rkey_q;
  logic           m_we, m_re;
  logic [NW-1:0]  m_waddr, m_raddr;
  logic [1:0]     m_wkind, m_rkind_q;
  logic [CW-1:0]  m_wslot, m_rslot_q;

  logic           rv_q;
  logic [1:0]     rstat_q;
  logic           rpv_q;
  logic [IDW-1:0] rpn_q;
  logic [CW-1:0]  rcnt_q;
  logic           rempty_q;
  logic           rsp_load;

  logic           req_fire;
  opcode_e        op;
  logic           id_oor;
  logic [PW-1:0]  in_key;
  logic           mark_hit, chk_hit, vis, refuse, full;
  logic           has_parent, up_stop, has_left, has_right;
  logic [CW:0]    c_left, c_right;
  logic           take_r, dn_stop;
  logic [IDW-1:0] best_node;
  logic [PW-1:0]  best_key;
  logic [CW-1:0]  best_idx;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign op          = opcode_e'(req_i.opcode);
  assign id_oor      = (32'(req_i.node_id) >= 32'(NODE_COUNT));
  // Flipping the sign bit lets an unsigned compare order the priorities.
  assign in_key      = {~req_i.priority_req[PW-1], req_i.priority_req[PW-2:0]};

  assign mark_hit   = (m_rkind_q == KIND_QUEUED) && (m_rslot_q != '0) &&
                      (m_rslot_q <= cnt_q);
  assign chk_hit    = (h_rnode_q == node_q);
  // A queued mark whose slot does not hold the node is stale and counts as visited.
  assign vis        = (state_q == S_CHK) ||
                      (m_rkind_q == KIND_VISITED) || (m_rkind_q == KIND_QUEUED);
  assign refuse     = vis && !multi_q;
  assign full       = (cnt_q >= CW'(HEAP_CAPACITY));
  assign has_parent = (k_q > CW'(1));
  assign up_stop    = (h_rkey_q > key_q);
  assign c_left     = {k_q, 1'b0};
  assign c_right    = c_left + 1'b1;
  assign has_left   = (c_left <= {1'b0, cnt_q});
  assign has_right  = (c_right <= {1'b0, cnt_q});
  assign take_r     = (state_q == S_DN_R) && (h_rkey_q > ckey_q);

  always_comb begin
    if (state_q == S_DN_R && !take_r) begin
      best_node = cnode_q;
      best_key  = ckey_q;
      best_idx  = CW'(c_left);
    end else begin
      best_node = h_rnode_q;
      best_key  = h_rkey_q;
      best_idx  = take_r ? CW'(c_right) : CW'(c_left);
    end
  end
  assign dn_stop = (key_q > best_key);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == NW'(NODE_COUNT - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req_fire) begin
          case (op)
            OP_PUSH: state_d = id_oor ? S_FIN : S_MARK;
            OP_POP:  state_d = (cnt_q == '0) ? S_FIN : S_POP_TOP;
            default: state_d = S_FIN;
          endcase
        end
      end
      S_MARK: begin
        if (mark_hit) state_d = S_CHK;
        else if (refuse || full) state_d = S_FIN;
        else state_d = S_UP;
      end
      S_CHK: begin
        if (chk_hit) state_d = multi_q ? S_UP : S_FIN;
        else if (refuse || full) state_d = S_FIN;
        else state_d = S_UP;
      end
      S_UP:       state_d = has_parent ? S_UP_CMP : S_FIN;
      S_UP_CMP:   state_d = up_stop ? S_FIN : S_UP;
      S_POP_TOP:  state_d = S_POP_LAST;
      S_POP_LAST: state_d = (cnt_q > CW'(1)) ? S_DN : S_POP_MARK;
      S_DN:       state_d = has_left ? S_DN_L : S_POP_MARK;
      S_DN_L: begin
        if (has_right) state_d = S_DN_R;
        else state_d = dn_stop ? S_POP_MARK : S_DN;
      end
      S_DN_R:     state_d = dn_stop ? S_POP_MARK : S_DN;
      S_POP_MARK: state_d = S_FIN;
      S_FIN:      state_d = rsp_load ? S_IDLE : S_FIN;
      default:    state_d = S_IDLE;
    endcase
  end

  // Datapath and memory controls.
  always_comb begin
    clr_d   = clr_q;
    cnt_d   = cnt_q;
    k_d     = k_q;
    node_d  = node_q;
    key_d   = key_q;
    top_d   = top_q;
    cnode_d = cnode_q;
    ckey_d  = ckey_q;
    st_d    = st_q;
    pv_d    = pv_q;
    h_we    = 1'b0;
    h_re    = 1'b0;
    h_waddr = k_q;
    h_raddr = k_q;
    h_wnode = node_q;
    h_wkey  = key_q;
    m_we    = 1'b0;
    m_re    = 1'b0;
    m_waddr = NW'(node_q);
    m_raddr = NW'(req_i.node_id);
    m_wkind = KIND_QUEUED;
    m_wslot = k_q;
    rsp_load = 1'b0;
    case (state_q)
      S_CLEAR: begin
        m_we    = 1'b1;
        m_waddr = clr_q;
        m_wkind = KIND_UNVISITED;
        m_wslot = '0;
        clr_d   = clr_q + 1'b1;
      end
      S_IDLE: begin
        if (req_fire) begin
          node_d = req_i.node_id;
          key_d  = in_key;
          st_d   = ST_OK;
          pv_d   = 1'b0;
          top_d  = '0;
          case (op)
            OP_PUSH: begin
              if (id_oor) st_d = ST_NOT_NEW;
              else m_re = 1'b1;
            end
            OP_POP: begin
              if (cnt_q == '0) begin
                st_d = ST_EMPTY;
              end else begin
                h_re    = 1'b1;
                h_raddr = CW'(1);
              end
            end
            OP_CLEAR: cnt_d = '0;
            default: ;
          endcase
        end
      end
      S_MARK, S_CHK: begin
        if (state_q == S_MARK && mark_hit) begin
          h_re    = 1'b1;
          h_raddr = m_rslot_q;
          k_d     = m_rslot_q;
        end else if (state_q == S_CHK && chk_hit) begin
          st_d = ST_NOT_NEW;
        end else if (refuse) begin
          st_d = ST_NOT_NEW;
        end else if (full) begin
          st_d = ST_FULL;
        end else begin
          cnt_d = cnt_q + 1'b1;
          k_d   = cnt_q + 1'b1;
        end
      end
      S_UP: begin
        if (has_parent) begin
          h_re    = 1'b1;
          h_raddr = k_q >> 1;
        end else begin
          h_we = 1'b1;
          m_we = 1'b1;
        end
      end
      S_UP_CMP: begin
        h_we = 1'b1;
        m_we = 1'b1;
        if (!up_stop) begin
          h_wnode = h_rnode_q;
          h_wkey  = h_rkey_q;
          m_waddr = NW'(h_rnode_q);
          k_d     = k_q >> 1;
        end
      end
      S_POP_TOP: begin
        top_d   = h_rnode_q;
        h_re    = 1'b1;
        h_raddr = cnt_q;
      end
      S_POP_LAST: begin
        node_d = h_rnode_q;
        key_d  = h_rkey_q;
        cnt_d  = cnt_q - 1'b1;
        k_d    = CW'(1);
      end
      S_DN: begin
        if (has_left) begin
          h_re    = 1'b1;
          h_raddr = CW'(c_left);
        end else begin
          h_we = 1'b1;
          m_we = 1'b1;
        end
      end
      S_DN_L, S_DN_R: begin
        if (state_q == S_DN_L && has_right) begin
          cnode_d = h_rnode_q;
          ckey_d  = h_rkey_q;
          h_re    = 1'b1;
          h_raddr = CW'(c_right);
        end else begin
          h_we = 1'b1;
          m_we = 1'b1;
          if (!dn_stop) begin
            h_wnode = best_node;
            h_wkey  = best_key;
            m_waddr = NW'(best_node);
            k_d     = best_idx;
          end
        end
      end
      S_POP_MARK: begin
        m_we    = 1'b1;
        m_waddr = NW'(top_q);
        m_wkind = KIND_VISITED;
        m_wslot = '0;
        pv_d    = 1'b1;
      end
      S_FIN: begin
        rsp_load = !rv_q || rsp_o.ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      cnt_q   <= '0;
      multi_q <= 1'b0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
      if (multi_enqueue_we_i) multi_q <= multi_enqueue_i;
      if (rsp_load) rv_q <= 1'b1;
      else if (rsp_o.ready) rv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q     <= k_d;
    node_q  <= node_d;
    key_q   <= key_d;
    top_q   <= top_d;
    cnode_q <= cnode_d;
    ckey_q  <= ckey_d;
    st_q    <= st_d;
    pv_q    <= pv_d;
    if (rsp_load) begin
      rstat_q  <= st_q;
      rpv_q    <= pv_q;
      rpn_q    <= pv_q ? top_q : '0;
      rcnt_q   <= cnt_q;
      rempty_q <= (cnt_q == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (h_we) begin
      heap_node_mem[h_waddr] <= h_wnode;
      heap_key_mem[h_waddr]  <= h_wkey;
    end
    if (h_re) begin
      h_rnode_q <= heap_node_mem[h_raddr];
      h_rkey_q  <= heap_key_mem[h_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_we) begin
      mark_kind_mem[m_waddr] <= m_wkind;
      mark_slot_mem[m_waddr] <= m_wslot;
    end
    if (m_re) begin
      m_rkind_q <= mark_kind_mem[m_raddr];
      m_rslot_q <= mark_slot_mem[m_raddr];
    end
  end

  assign rsp_o.valid        = rv_q;
  assign rsp_o.status       = rstat_q;
  assign rsp_o.popped_valid = rpv_q;
  assign rsp_o.popped_node  = rpn_q;
  assign rsp_o.entry_count  = rcnt_q;
  assign rsp_o.is_empty     = rempty_q;

endmodule
